/* hdl/xo256pp_pkg.sv */
// ----------------------------------------------------------------------------
// xo256pp_pkg
// Shared types, constants and step functions of the xoshiro256++ generator.
// ----------------------------------------------------------------------------
package xo256pp_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned NWords = 4;
  localparam int unsigned PolyW  = WordW * NWords;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NWords-1:0][WordW-1:0] state_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_GEN  = 2'd1,
    ACT_JUMP = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // Jump polynomial, word 0 in the low bits so that bit n is step n.
  localparam logic [PolyW-1:0] JumpPoly = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };

  localparam logic [3:0] MaxBytes = 4'd8;

  function automatic word_t rotl23(word_t x);
    return {x[40:0], x[63:41]};
  endfunction

  function automatic word_t rotl45(word_t x);
    return {x[18:0], x[63:19]};
  endfunction

  // One xoshiro256 state transition.
  function automatic state_t step(state_t s);
    state_t n;
    word_t  t;
    t    = {s[1][46:0], 17'd0};
    n[2] = s[2] ^ s[0] ^ t;
    n[3] = rotl45(s[3] ^ s[1]);
    n[1] = s[1] ^ s[2] ^ s[0];
    n[0] = s[0] ^ s[3] ^ s[1];
    return n;
  endfunction

  function automatic word_t scramble(state_t s);
    return rotl23(s[0] + s[3]) + s[0];
  endfunction

  // Keeps the top n bytes of a word.
  function automatic word_t byte_mask(logic [3:0] n);
    word_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[WordW-1-8*i -: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

/* hdl/xo256pp_if.sv */
// ----------------------------------------------------------------------------
// xo256pp_if
// Valid/ready channels carrying requests into and results out of the generator.
// ----------------------------------------------------------------------------
interface xo256pp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  word_index;
  logic [63:0] seed_word;
  logic [3:0]  byte_count;

  modport source (output valid, action, word_index, seed_word, byte_count, input ready);
  modport sink   (input valid, action, word_index, seed_word, byte_count, output ready);
endinterface

interface xo256pp_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] bytes_out;
  logic [3:0]  valid_bytes;
  logic        seed_weak;

  modport source (output valid, bytes_out, valid_bytes, seed_weak, input ready);
  modport sink   (input valid, bytes_out, valid_bytes, seed_weak, output ready);
endinterface

/* hdl/xoshiro256pp_generator_with_jump.sv */
// ----------------------------------------------------------------------------
// xoshiro256pp_generator_with_jump
// Xoshiro256++ generator with seed load, generate and 2^128-step jump.
// ----------------------------------------------------------------------------
// A load or a generate beat is accepted while the generator is idle and its
// result is registered for the following cycle, so those actions sustain one
// beat per cycle while results are taken. A jump holds the request channel
// off from acceptance until its result appears: the single state-step unit
// runs once per polynomial bit but the last while an accumulator gathers the
// state, and the result appears once the accumulated value has replaced the
// state. Every result reports whether state words 0 and 1 are both zero
// after the action.
module xoshiro256pp_generator_with_jump
  import xo256pp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  xo256pp_req_if.sink          in_i,
  xo256pp_rsp_if.source        out_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_JUMP = 2'b10
  } state_e;

  state_e     st_q, st_d;
  state_t     s_q, s_d;
  state_t     acc_q, acc_d;
  state_t     s_next;
  logic [7:0] cnt_q, cnt_d;

  logic       out_valid_q, out_valid_d;
  word_t      bytes_q, bytes_d;
  logic [3:0] vbytes_q, vbytes_d;
  logic       weak_q, weak_d;

  logic       in_fire;
  logic       out_fire;
  logic [3:0] count_sat;
  action_e    act;
  state_t     acc_upd;

  assign out_fire = out_valid_q & out_o.ready;
  assign in_i.ready = (st_q == ST_IDLE) & (~out_valid_q | out_o.ready);
  assign in_fire = in_i.valid & in_i.ready;
  assign act = action_e'(in_i.action);
  assign count_sat = (in_i.byte_count > MaxBytes) ? MaxBytes : in_i.byte_count;

  // The shared step unit: used by a generate beat and by every jump cycle but the last.
  assign s_next = step(s_q);
  assign acc_upd = JumpPoly[cnt_q] ? (acc_q ^ s_q) : acc_q;

  always_comb begin
    st_d        = st_q;
    s_d         = s_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_fire;
    bytes_d     = bytes_q;
    vbytes_d    = vbytes_q;
    weak_d      = weak_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          bytes_d  = '0;
          vbytes_d = '0;
          case (act)
            ACT_LOAD: s_d[in_i.word_index] = in_i.seed_word;
            ACT_GEN: begin
              if (count_sat != 4'd0) begin
                s_d      = s_next;
                bytes_d  = scramble(s_q) & byte_mask(count_sat);
                vbytes_d = count_sat;
              end
            end
            ACT_JUMP: begin
              st_d  = ST_JUMP;
              acc_d = '0;
              cnt_d = '0;
            end
            default: ;
          endcase
          weak_d      = (s_d[0] == '0) && (s_d[1] == '0);
          out_valid_d = (act != ACT_JUMP);
        end
      end
      ST_JUMP: begin
        acc_d = acc_upd;
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == 8'hFF) begin
          // Last polynomial bit: the accumulator becomes the new state.
          s_d         = acc_upd;
          st_d        = ST_IDLE;
          weak_d      = (acc_upd[0] == '0) && (acc_upd[1] == '0);
          out_valid_d = 1'b1;
        end else begin
          s_d = s_next;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      s_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      s_q         <= s_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    bytes_q  <= bytes_d;
    vbytes_q <= vbytes_d;
    weak_q   <= weak_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.bytes_out   = bytes_q;
  assign out_o.valid_bytes = vbytes_q;
  assign out_o.seed_weak   = weak_q;

`ifndef SYNTHESIS
  a_no_result_in_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_JUMP) |-> !out_valid_q)
    else $error("result pending while a jump is running");

  a_jump_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act == ACT_JUMP) |=> (st_q == ST_JUMP) && (cnt_q == 8'd0))
    else $error("accepted jump did not start the sequencer");

  a_jump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_JUMP && cnt_q == 8'hFF) |=> (st_q == ST_IDLE) && out_valid_q)
    else $error("jump did not finish with a result");

  a_other_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act != ACT_JUMP) |=> out_valid_q)
    else $error("load or generate beat produced no result");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && vbytes_q == 4'd0) |-> (bytes_q == '0))
    else $error("result with no valid bytes carries data");
`endif

endmodule
